// ===== hdl/matrix_multiply_engine_assert.svh =====
// Assertion helpers for the matrix multiply engine checker.
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define MME_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mme assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mme assertion failed");

`endif

// ===== hdl/mme_pkg.sv =====
package mme_pkg;

  localparam int MAX_DIM     = 8;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int DEPTH       = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int SIZE_W      = 4;
  localparam int FIELD_W     = 3;
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD_A   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B   = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS     = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_tag_t;

  // size register -> last index (0 counts as 1, clipped at MAX_DIM)
  function automatic logic [IDX_W-1:0] size_last(input logic [SIZE_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > MAX_DIM) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(v - 1'b1);
    end
    return res;
  endfunction

  // arithmetic shift by FRAC_BITS, then saturate to DATA_W bits
  function automatic logic signed [DATA_W-1:0] shift_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]  sh;
    logic signed [DATA_W-1:0] res;
    sh = acc >>> FRAC_BITS;
    if ((&sh[ACC_W-1:DATA_W-1]) || !(|sh[ACC_W-1:DATA_W-1])) begin
      res = sh[DATA_W-1:0];
    end else if (sh[ACC_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== hdl/mme_store.sv =====
// One matrix store: single write port, single registered read port.
module mme_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [mme_pkg::ADDR_W-1:0] waddr_i,
  input  logic [mme_pkg::DATA_W-1:0] wdata_i,
  input  logic [mme_pkg::ADDR_W-1:0] raddr_i,
  output logic [mme_pkg::DATA_W-1:0] rdata_o
);
  import mme_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/mme_mac.sv =====
// Shared multiply-accumulate unit. Tag enters with the read address,
// lines up with store read data in the next cycle, with the product in the cycle after that.
module mme_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mme_pkg::mac_tag_t                 tag_i,
  input  logic signed [mme_pkg::DATA_W-1:0] a_i,
  input  logic signed [mme_pkg::DATA_W-1:0] b_i,
  output logic signed [mme_pkg::ACC_W-1:0]  acc_o,
  output logic                              done_o
);
  import mme_pkg::*;

  mac_tag_t                 rd_tag_q;
  mac_tag_t                 prod_tag_q;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q   <= '0;
      prod_tag_q <= '0;
      done_q     <= 1'b0;
    end else begin
      rd_tag_q   <= tag_i;
      prod_tag_q <= rd_tag_q;
      done_q     <= prod_tag_q.vld && prod_tag_q.last;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (prod_tag_q.vld) begin
      acc_d = prod_tag_q.first ? prod_q : acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// ===== hdl/matrix_multiply_engine.sv =====
// Dense matrix multiply engine, signed Q16.16 elements.
// Input stream (s_axis): tuser carries the op. Load-A / load-B items write one
// element at (row_index, col_index); out-of-range indexes and
// op 3 are dropped. A multiply item starts a run that emits a_rows x b_cols
// result items in row-major order on m_axis; tlast marks the final one.
// Config port: cfg_we_i writes a_rows (0), inner_size (1), b_cols (2);
// sizes of 0 act as 1, sizes above MAX_DIM act as MAX_DIM.
// Sequencing: each result element takes inner_size store reads through the
// single shared 32x32 multiplier, then passes the read register, the
// product register and the accumulator flush, and ends with one output
// load. s_axis_tready is low for the whole run and high otherwise.
// Backpressure: results sit in one output register; if m_axis_tready stays
// low the sequencer holds in its emit step, nothing is dropped.
// Reset (rst_ni low, async) returns the sequencer to idle, clears the output
// valid and sets all sizes to 8. Store contents are not cleared; elements
// must be written before they are used.
module matrix_multiply_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // cfg
  input  logic                                cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mme_pkg::SIZE_W-1:0]          cfg_data_i,
  // input item stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: row_index[2:0], col_index[5:3], element_value[37:6], zero pad[39:38]
  input  logic [mme_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: op[1:0]
  input  logic [mme_pkg::OP_W-1:0]            s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: out_row[2:0], out_col[5:3], out_value[37:6], zero pad[39:38]
  output logic [mme_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);
  import mme_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  // size registers
  logic [SIZE_W-1:0] a_rows_q, inner_size_q, b_cols_q;

  // run counters and latched last indexes
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [IDX_W-1:0] nr_q, nr_d, nk_q, nk_d, nc_q, nc_d;

  // unpacked input item
  logic [FIELD_W-1:0]       in_row, in_col;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_acc;
  logic                     in_range;

  logic               we_a, we_b;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr_a, raddr_b;
  logic [DATA_W-1:0]  rdata_a, rdata_b;

  mac_tag_t                 tag;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_done;

  // output register
  logic                     out_vld_q, out_vld_d;
  logic [FIELD_W-1:0]       out_row_q, out_col_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_last_q;
  logic                     out_load;
  logic                     out_free;
  logic                     elem_last;

  assign in_row   = s_axis_tdata[FIELD_W-1:0];
  assign in_col   = s_axis_tdata[2*FIELD_W-1:FIELD_W];
  assign in_value = s_axis_tdata[2*FIELD_W+DATA_W-1:2*FIELD_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_range      = (in_row < MAX_DIM) && (in_col < MAX_DIM);

  assign we_a  = in_acc && in_range && (s_axis_tuser == OP_LOAD_A);
  assign we_b  = in_acc && in_range && (s_axis_tuser == OP_LOAD_B);
  assign waddr = ADDR_W'(in_row * MAX_DIM + in_col);

  assign raddr_a = ADDR_W'(r_q * MAX_DIM + k_q);
  assign raddr_b = ADDR_W'(k_q * MAX_DIM + c_q);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q     <= SIZE_RESET;
      inner_size_q <= SIZE_RESET;
      b_cols_q     <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_A_ROWS:     a_rows_q     <= cfg_data_i;
        CFG_INNER_SIZE: inner_size_q <= cfg_data_i;
        CFG_B_COLS:     b_cols_q     <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  mme_store u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mme_store u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign tag.vld   = (state_q == ST_ISSUE);
  assign tag.first = (k_q == '0);
  assign tag.last  = (k_q == nk_q);

  mme_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .acc_o  (acc),
    .done_o (acc_done)
  );

  assign out_free  = !out_vld_q || m_axis_tready;
  assign elem_last = (r_q == nr_q) && (c_q == nc_q);
  assign out_load  = (state_q == ST_EMIT) && out_free;

  // sequencer
  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    c_d       = c_q;
    k_d       = k_q;
    nr_d      = nr_q;
    nk_d      = nk_q;
    nc_d      = nc_q;
    out_vld_d = out_vld_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == OP_MULTIPLY)) begin
          nr_d    = size_last(a_rows_q);
          nk_d    = size_last(inner_size_q);
          nc_d    = size_last(b_cols_q);
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_q == nk_q) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (acc_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          k_d       = '0;
          if (elem_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            if (c_q == nc_q) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      r_q       <= '0;
      c_q       <= '0;
      k_q       <= '0;
      nr_q      <= '0;
      nk_q      <= '0;
      nc_q      <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      r_q       <= r_d;
      c_q       <= c_d;
      k_q       <= k_d;
      nr_q      <= nr_d;
      nk_q      <= nk_d;
      nc_q      <= nc_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q   <= FIELD_W'(r_q);
      out_col_q   <= FIELD_W'(c_q);
      out_value_q <= shift_sat(acc);
      out_last_q  <= elem_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2*FIELD_W-DATA_W){1'b0}},
                          out_value_q, out_col_q, out_row_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/mme_checker.sv =====
`include "matrix_multiply_engine_assert.svh"

module mme_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [mme_pkg::OP_W-1:0]        s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import mme_pkg::*;

  // stalled result holds
  `MME_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // a multiply item makes the engine busy
  `MME_ASSERT_NEXT(a_busy_after_mul, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_MULTIPLY, !s_axis_tready)

  // no new item while a run is still emitting
  `MME_ASSERT_IMPL(a_busy_mid_run, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

  // a load taken with no result pending makes no result
  `MME_ASSERT_NEXT(a_load_quiet, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_MULTIPLY && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_matrix_multiply_engine.sv =====
module tb_matrix_multiply_engine;
  import mme_pkg::*;

  // op 3 has no name in the package; the engine drops it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned DRAIN_CAP     = 50_000;
  // a run ends with one last output load
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef enum logic {STEP_ITEM, STEP_SIZES} step_kind_e;

  // One stimulus step. STEP_SIZES rows carry the three sizes in value:
  // a_rows [3:0], inner_size [7:4], b_cols [11:8].
  typedef struct packed {
    step_kind_e        kind;
    logic [OP_W-1:0]   op;
    logic [2:0]        row;
    logic [2:0]        col;
    logic [31:0]       value;
    logic              typed;    // single-element product known by hand
    logic [31:0]       product;
  } engine_step_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } product_elem_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = CFG_A_ROWS;
  logic [SIZE_W-1:0]      cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // row[2:0], col[5:3], value[37:6], pad
  logic [OP_W-1:0]        s_axis_tuser = OP_LOAD_A;  // op[1:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // row[2:0], col[5:3], value[37:6], pad
  logic                   m_axis_tlast;

  matrix_multiply_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the engine: both matrices, which entries hold data,
  // and the three size registers.
  logic signed [31:0] a_elems [MAX_DIM*MAX_DIM];
  logic signed [31:0] b_elems [MAX_DIM*MAX_DIM];
  bit                 a_loaded [MAX_DIM*MAX_DIM];
  bit                 b_loaded [MAX_DIM*MAX_DIM];
  logic [SIZE_W-1:0]  rows_sz  = SIZE_RESET;
  logic [SIZE_W-1:0]  inner_sz = SIZE_RESET;
  logic [SIZE_W-1:0]  cols_sz  = SIZE_RESET;

  product_elem_t pending_products[$];

  int unsigned error_count   = 0;
  int unsigned items_issued  = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 85;

  // Directed part. Every step runs on 1x1x1 sizes (1x2x1 for the wrap case)
  // until the last block, so the expected element can be worked out by hand.
  engine_step_t directed_steps [29] = '{
    '{STEP_SIZES, OP_LOAD_A,   3'd0, 3'd0, 32'h0000_0111, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_B,   3'd0, 3'd0, 32'h0002_0000, 1'b0, 32'h0},
    // 1.0 * 2.0; row and column fields are don't-care on a multiply
    '{STEP_ITEM,  OP_MULTIPLY, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'h0002_0000},
    // unused op must not touch the stores
    '{STEP_ITEM,  OP_UNUSED,   3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_B,   3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0},
    // -2^-32 floors to one negative lsb
    '{STEP_ITEM,  OP_MULTIPLY, 3'd0, 3'd0, 32'h0,         1'b1, 32'hFFFF_FFFF},
    '{STEP_ITEM,  OP_LOAD_A,   3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_B,   3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    // most negative squared saturates high
    '{STEP_ITEM,  OP_MULTIPLY, 3'd0, 3'd0, 32'h0,         1'b1, 32'h7FFF_FFFF},
    '{STEP_ITEM,  OP_LOAD_B,   3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_MULTIPLY, 3'd0, 3'd0, 32'h0,         1'b1, 32'h8000_0000},
    '{STEP_SIZES, OP_LOAD_A,   3'd0, 3'd0, 32'h0000_0121, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd0, 3'd1, 32'h8000_0000, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_B,   3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_B,   3'd1, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    // 2^62 + 2^62 wraps the accumulator negative: low rail, not high
    '{STEP_ITEM,  OP_MULTIPLY, 3'd0, 3'd0, 32'h0,         1'b1, 32'h8000_0000},
    // zero sizes act as one
    '{STEP_SIZES, OP_LOAD_A,   3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_MULTIPLY, 3'd0, 3'd0, 32'h0,         1'b1, 32'h7FFF_FFFF},
    // a_rows of 15 clips to 8: an 8x1 column from the predictor
    '{STEP_SIZES, OP_LOAD_A,   3'd0, 3'd0, 32'h0000_000F, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd1, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd2, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd3, 3'd0, 32'h0001_8000, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd4, 3'd0, 32'hFFFE_8000, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd5, 3'd0, 32'h1234_5678, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd6, 3'd0, 32'hEDCB_A987, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_LOAD_A,   3'd7, 3'd0, 32'h0000_0001, 1'b0, 32'h0},
    '{STEP_ITEM,  OP_MULTIPLY, 3'd0, 3'd0, 32'h0,         1'b0, 32'h0}
  };

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Applies one accepted item to the shadow stores; a multiply queues the
  // whole product in row-major order.
  function automatic void predict_products(input engine_step_t it);
    int unsigned        nr, nk, nc, r, c, k;
    logic signed [63:0] acc, lhs, rhs, quo;
    product_elem_t      e;
    case (it.op)
      OP_LOAD_A: begin
        a_elems[int'(it.row)*MAX_DIM + int'(it.col)]  = it.value;
        a_loaded[int'(it.row)*MAX_DIM + int'(it.col)] = 1'b1;
      end
      OP_LOAD_B: begin
        b_elems[int'(it.row)*MAX_DIM + int'(it.col)]  = it.value;
        b_loaded[int'(it.row)*MAX_DIM + int'(it.col)] = 1'b1;
      end
      OP_MULTIPLY: begin
        nr = eff_size(rows_sz);
        nk = eff_size(inner_sz);
        nc = eff_size(cols_sz);
        for (r = 0; r < nr; r++) begin
          for (c = 0; c < nc; c++) begin
            acc = '0;
            for (k = 0; k < nk; k++) begin
              lhs = a_elems[r*MAX_DIM + k];
              rhs = b_elems[k*MAX_DIM + c];
              acc = acc + lhs * rhs;  // wraps at 64 bits
            end
            quo = acc >>> FRAC_BITS;
            if (quo > 64'sh0000_0000_7FFF_FFFF) e.value = 32'h7FFF_FFFF;
            else if (quo < -64'sh0000_0000_8000_0000) e.value = 32'h8000_0000;
            else e.value = quo[31:0];
            if (it.typed) e.value = it.product;
            e.row  = 3'(r);
            e.col  = 3'(c);
            e.last = (r == nr - 1) && (c == nc - 1);
            pending_products.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
      3, 4: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;  // within +-4.0
      default: return $urandom();
    endcase
  endfunction

  // mostly inside the active region, sometimes anywhere
  function automatic logic [2:0] pick_index(input int unsigned n);
    if ($urandom_range(0, 4) != 0) return 3'($urandom_range(0, n - 1));
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'($urandom_range(9, 15));
      2: return SIZE_W'(MAX_DIM);
      default: return SIZE_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_item(input engine_step_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {2'b00, it.value, it.col, it.row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_products(it);
    if (it.op != OP_UNUSED) items_issued++;
  endtask

  // Wait until every queued element is back, then let the engine go quiet.
  task automatic settle_engine();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_products.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_sizes(input logic [SIZE_W-1:0] rows, inner, cols);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_A_ROWS;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    cfg_index_i <= CFG_INNER_SIZE;
    cfg_data_i  <= inner;
    @(posedge clk_i);
    cfg_index_i <= CFG_B_COLS;
    cfg_data_i  <= cols;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rows_sz  = rows;
    inner_sz = inner;
    cols_sz  = cols;
  endtask

  // A well-formed run: maybe new sizes, random loads with some noise,
  // fill whatever the product would read unwritten, then multiply.
  // Now and then the fill and the multiply are dropped to leave a loads-only sequence.
  task automatic random_sequence();
    int unsigned  nr, nk, nc, r, c;
    engine_step_t it;
    if ($urandom_range(0, 3) == 0) begin
      settle_engine();
      program_sizes(pick_size(), pick_size(), pick_size());
    end
    nr = eff_size(rows_sz);
    nk = eff_size(inner_sz);
    nc = eff_size(cols_sz);
    repeat ($urandom_range(0, 8)) begin
      it = '0;
      it.kind  = STEP_ITEM;
      it.value = pick_value();
      if ($urandom_range(0, 1) != 0) begin
        it.op  = OP_LOAD_B;
        it.row = pick_index(nk);
        it.col = pick_index(nc);
      end else begin
        it.op  = OP_LOAD_A;
        it.row = pick_index(nr);
        it.col = pick_index(nk);
      end
      send_item(it);
      if ($urandom_range(0, 9) == 0) begin
        it.op    = OP_UNUSED;
        it.row   = 3'($urandom_range(0, 7));
        it.col   = 3'($urandom_range(0, 7));
        it.value = $urandom();
        send_item(it);
      end
    end
    if ($urandom_range(0, 7) == 0) return;
    it = '0;
    it.kind = STEP_ITEM;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nk; c++) begin
        if (!a_loaded[r*MAX_DIM + c]) begin
          it.op    = OP_LOAD_A;
          it.row   = 3'(r);
          it.col   = 3'(c);
          it.value = pick_value();
          send_item(it);
        end
      end
    end
    for (r = 0; r < nk; r++) begin
      for (c = 0; c < nc; c++) begin
        if (!b_loaded[r*MAX_DIM + c]) begin
          it.op    = OP_LOAD_B;
          it.row   = 3'(r);
          it.col   = 3'(c);
          it.value = pick_value();
          send_item(it);
        end
      end
    end
    it.op    = OP_MULTIPLY;
    it.row   = 3'($urandom_range(0, 7));
    it.col   = 3'($urandom_range(0, 7));
    it.value = $urandom();
    send_item(it);
  endtask

  // Result side: random backpressure and in-order compare.
  always @(posedge clk_i) begin
    product_elem_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6], m_axis_tlast};
        if (pending_products.size() == 0) begin
          if (error_count < 10)
            $display("unexpected element: row %0d col %0d value %h last %b",
                     got.row, got.col, got.value, got.last);
          error_count++;
        end else begin
          want = pending_products.pop_front();
          if (got.row != want.row || got.col != want.col ||
              got.value != want.value || got.last != want.last) begin
            if (error_count < 10)
              $display("element mismatch: want row %0d col %0d value %h last %b, got row %0d col %0d value %h last %b",
                       want.row, want.col, want.value, want.last,
                       got.row, got.col, got.value, got.last);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("matrix_multiply_engine verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase, phase_end;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_SIZES) begin
        settle_engine();
        program_sizes(directed_steps[i].value[3:0], directed_steps[i].value[7:4],
                      directed_steps[i].value[11:8]);
      end else begin
        send_item(directed_steps[i]);
      end
    end

    // Three idling regimes: sender rarely idle / receiver mostly idle, swapped, none.
    for (phase = 0; phase < 3; phase++) begin
      settle_engine();
      case (phase)
        0: begin send_idle_pct = 8;  recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_end = items_issued + 135;
      while (items_issued < phase_end) random_sequence();
    end

    settle_engine();
    if (pending_products.size() != 0) begin
      $display("%0d expected elements never arrived", pending_products.size());
      error_count += pending_products.size();
    end
    if (error_count == 0) begin
      $display("matrix_multiply_engine verification clean");
    end else begin
      $display("matrix_multiply_engine verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mme_pkg.sv
hdl/mme_store.sv
hdl/mme_mac.sv
hdl/matrix_multiply_engine.sv
hdl/mme_checker.sv
verif/tb_matrix_multiply_engine.sv
